### rtl/core/wpf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpf_pkg
// Shared types and constants for the waypoint path follower.
// ----------------------------------------------------------------------------
package wpf_pkg;

  localparam int MAX_POINTS   = 256;
  localparam int PT_AW        = $clog2(MAX_POINTS);
  localparam int CNT_W        = PT_AW + 1;
  localparam int CORDIC_STEPS = 16;
  localparam int IT_W         = $clog2(CORDIC_STEPS);

  localparam logic signed [20:0] PI_Q16     = 21'sd205887;
  localparam logic signed [17:0] PI_Q13     = 18'sd25736;
  localparam logic signed [17:0] TWO_PI_Q13 = 18'sd51472;

  typedef enum logic [2:0] {
    OP_TICK    = 3'd0,
    OP_NEW     = 3'd1,
    OP_ADD     = 3'd2,
    OP_FIRST   = 3'd3,
    OP_NEAREST = 3'd4,
    OP_CLEAR   = 3'd5,
    OP_PAUSE   = 3'd6,
    OP_RESUME  = 3'd7
  } op_e;

  typedef enum logic [2:0] {
    ST_NONE    = 3'd0,
    ST_DONE    = 3'd1,
    ST_NO_PATH = 3'd2,
    ST_CLEARED = 3'd3,
    ST_PLAN    = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    CFG_ROT_GAIN  = 3'd0,
    CFG_DRV_GAIN  = 3'd1,
    CFG_ANG_TOL   = 3'd2,
    CFG_ARRIVE    = 3'd3,
    CFG_CRUISE    = 3'd4,
    CFG_TURN_LIM  = 3'd5
  } cfg_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIFF,
    S_CORD,
    S_ERR,
    S_TMUL,
    S_TURN,
    S_SQX,
    S_SQY,
    S_SQR,
    S_DCMP,
    S_NDIFF,
    S_NSQX,
    S_NSQY,
    S_NCMP
  } state_e;

  typedef struct packed {
    op_e                opcode;
    logic signed [31:0] x_coord;
    logic signed [31:0] y_coord;
    logic signed [15:0] heading;
  } in_t;

  typedef struct packed {
    logic               has_twist;
    logic [14:0]        linear_speed;
    logic signed [15:0] turn_rate;
    status_e            status;
  } out_t;

  // arctan(2^-i) in rad Q16
  function automatic logic [19:0] atan_q16(input logic [IT_W-1:0] i);
    logic [19:0] r;
    case (i)
      4'd0:    r = 20'd51472;
      4'd1:    r = 20'd30385;
      4'd2:    r = 20'd16055;
      4'd3:    r = 20'd8150;
      4'd4:    r = 20'd4091;
      4'd5:    r = 20'd2047;
      4'd6:    r = 20'd1024;
      4'd7:    r = 20'd512;
      4'd8:    r = 20'd256;
      4'd9:    r = 20'd128;
      4'd10:   r = 20'd64;
      4'd11:   r = 20'd32;
      4'd12:   r = 20'd16;
      4'd13:   r = 20'd8;
      4'd14:   r = 20'd4;
      4'd15:   r = 20'd2;
      default: r = 20'd0;
    endcase
    return r;
  endfunction

endpackage

### rtl/core/waypoint_path_follower_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// waypoint_path_follower_core
// Rotate-then-drive waypoint follower with on-chip point store.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o/in_data_i) carries one command word:
//   a pose tick or a path command. Output channel (out_valid_o/out_ready_i/
//   out_data_o) carries at most one result word per command.
//   Config writes (cfg_valid_i/cfg_index_i/cfg_data_i) are always taken.
//   Plain commands put their result out the cycle after accept.
//   A tick that reads a waypoint runs one 16-step CORDIC loop on a shared
//   shift-add unit, then passes through one 32x32 multiplier (turn rate,
//   squared distances and squared arrival radius).
//   Start-nearest walks the store one stored point at a time, through the
//   single read port and the shared multiplier.
//   The block takes one word at a time and is ready again only once it is idle
//   and any result word has been taken; a stalled receiver holds everything.
//   Reset clears all control state and loads the default gains; the point
//   store has no reset, only entries below the point count are read.
// ----------------------------------------------------------------------------
module waypoint_path_follower_core (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  wpf_pkg::in_t           in_data_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output wpf_pkg::out_t          out_data_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [2:0]             cfg_index_i,
  input  logic [31:0]            cfg_data_i
);

  wpf_pkg::state_e state_q, state_d;

  logic [15:0] rot_gain_q, drv_gain_q;
  logic [14:0] ang_tol_q, cruise_q, turn_lim_q;
  logic [30:0] arrive_q;

  logic [wpf_pkg::CNT_W-1:0] count_q, count_d, target_q, target_d;
  logic [wpf_pkg::CNT_W-1:0] scan_q, scan_d, best_idx_q, best_idx_d;
  logic following_q, following_d, plan_q, plan_d, paused_q, paused_d;
  logic rotfin_q, rotfin_d;
  logic signed [31:0] pose_x_q, pose_x_d, pose_y_q, pose_y_d;
  logic signed [15:0] hd_q, hd_d;

  logic signed [31:0] mem_x [wpf_pkg::MAX_POINTS];
  logic signed [31:0] mem_y [wpf_pkg::MAX_POINTS];
  logic signed [31:0] rdx_q, rdy_q;
  logic [wpf_pkg::PT_AW-1:0] rd_addr;
  logic mem_we;

  logic signed [35:0] cx_q, cx_d, cy_q, cy_d;
  logic signed [20:0] cz_q, cz_d;
  logic [wpf_pkg::IT_W-1:0] it_q, it_d;
  logic zero_q, zero_d;
  logic signed [17:0] err_q, err_d;
  logic [31:0] ax_q, ax_d, ay_q, ay_d;
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_q;
  logic [64:0] sq_q, sq_d, best_q, best_d;
  logic signed [15:0] turn_q, turn_d;

  wpf_pkg::out_t out_q, out_d;
  logic out_valid_q, out_valid_d;

  logic in_fire;
  logic signed [32:0] dx, dy;
  logic [32:0] adx, ady;
  logic signed [35:0] shx, shy;
  logic signed [20:0] atan_s, zr;
  logic signed [17:0] ang, e_raw;
  logic [17:0] err_mag;
  logic signed [34:0] prod_s;
  logic signed [21:0] t_full, lim;
  logic signed [15:0] turn_c;
  logic [64:0] sum_n;

  assign in_ready_o  = (state_q == wpf_pkg::S_IDLE) && !out_valid_q;
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign cfg_ready_o = 1'b1;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot_gain_q <= 16'd6144;
      drv_gain_q <= 16'd4096;
      ang_tol_q  <= 15'd82;
      arrive_q   <= 31'd3277;
      cruise_q   <= 15'd819;
      turn_lim_q <= 15'd4096;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        wpf_pkg::CFG_ROT_GAIN: rot_gain_q <= cfg_data_i[15:0];
        wpf_pkg::CFG_DRV_GAIN: drv_gain_q <= cfg_data_i[15:0];
        wpf_pkg::CFG_ANG_TOL:  ang_tol_q  <= cfg_data_i[14:0];
        wpf_pkg::CFG_ARRIVE:   arrive_q   <= cfg_data_i[30:0];
        wpf_pkg::CFG_CRUISE:   cruise_q   <= cfg_data_i[14:0];
        wpf_pkg::CFG_TURN_LIM: turn_lim_q <= cfg_data_i[14:0];
        default: ;
      endcase
    end
  end

  // point store, registered read
  assign mem_we = in_fire && (in_data_i.opcode == wpf_pkg::OP_ADD) &&
                  (count_q < wpf_pkg::CNT_W'(wpf_pkg::MAX_POINTS));

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_x[count_q[wpf_pkg::PT_AW-1:0]] <= in_data_i.x_coord;
      mem_y[count_q[wpf_pkg::PT_AW-1:0]] <= in_data_i.y_coord;
    end
    rdx_q <= mem_x[rd_addr];
    rdy_q <= mem_y[rd_addr];
  end

  // shared multiplier
  always_ff @(posedge clk_i) begin
    mul_q <= mul_a * mul_b;
  end

  // datapath helpers
  assign dx  = {rdx_q[31], rdx_q} - {pose_x_q[31], pose_x_q};
  assign dy  = {rdy_q[31], rdy_q} - {pose_y_q[31], pose_y_q};
  assign adx = dx[32] ? -dx : dx;
  assign ady = dy[32] ? -dy : dy;
  assign shx = cx_q >>> it_q;
  assign shy = cy_q >>> it_q;
  assign atan_s = {1'b0, wpf_pkg::atan_q16(it_q)};
  assign zr     = (cz_q + 21'sd4) >>> 3;
  assign ang    = zero_q ? 18'sd0 : zr[17:0];
  assign e_raw  = ang - {{2{hd_q[15]}}, hd_q};
  assign err_mag = err_q[17] ? 18'(-err_q) : 18'(err_q);
  assign prod_s = err_q[17] ? -$signed({1'b0, mul_q[33:0]})
                            :  $signed({1'b0, mul_q[33:0]});
  assign t_full = 22'((prod_s + 35'sd4096) >>> 13);
  assign lim    = $signed({7'd0, turn_lim_q});
  assign sum_n  = sq_q + {1'b0, mul_q};

  always_comb begin
    if (t_full > lim) begin
      turn_c = lim[15:0];
    end else if (t_full < -lim) begin
      turn_c = 16'(-lim);
    end else begin
      turn_c = t_full[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= wpf_pkg::S_IDLE;
      count_q     <= '0;
      target_q    <= '0;
      scan_q      <= '0;
      best_idx_q  <= '0;
      following_q <= 1'b0;
      plan_q      <= 1'b0;
      paused_q    <= 1'b0;
      rotfin_q    <= 1'b0;
      pose_x_q    <= '0;
      pose_y_q    <= '0;
      hd_q        <= '0;
      out_valid_q <= 1'b0;
      it_q        <= '0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      target_q    <= target_d;
      scan_q      <= scan_d;
      best_idx_q  <= best_idx_d;
      following_q <= following_d;
      plan_q      <= plan_d;
      paused_q    <= paused_d;
      rotfin_q    <= rotfin_d;
      pose_x_q    <= pose_x_d;
      pose_y_q    <= pose_y_d;
      hd_q        <= hd_d;
      out_valid_q <= out_valid_d;
      it_q        <= it_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cx_q   <= cx_d;
    cy_q   <= cy_d;
    cz_q   <= cz_d;
    zero_q <= zero_d;
    err_q  <= err_d;
    ax_q   <= ax_d;
    ay_q   <= ay_d;
    sq_q   <= sq_d;
    best_q <= best_d;
    turn_q <= turn_d;
    out_q  <= out_d;
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    target_d    = target_q;
    scan_d      = scan_q;
    best_idx_d  = best_idx_q;
    following_d = following_q;
    plan_d      = plan_q;
    paused_d    = paused_q;
    rotfin_d    = rotfin_q;
    pose_x_d    = pose_x_q;
    pose_y_d    = pose_y_q;
    hd_d        = hd_q;
    cx_d        = cx_q;
    cy_d        = cy_q;
    cz_d        = cz_q;
    it_d        = it_q;
    zero_d      = zero_q;
    err_d       = err_q;
    ax_d        = ax_q;
    ay_d        = ay_q;
    sq_d        = sq_q;
    best_d      = best_q;
    turn_d      = turn_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    mul_a       = '0;
    mul_b       = '0;
    rd_addr     = target_q[wpf_pkg::PT_AW-1:0];

    case (state_q)
      wpf_pkg::S_IDLE: begin
        if (in_data_i.opcode == wpf_pkg::OP_NEAREST) begin
          rd_addr = '0;
        end
        if (in_fire) begin
          out_d = '{has_twist: 1'b1, linear_speed: '0, turn_rate: '0,
                    status: wpf_pkg::ST_NONE};
          case (in_data_i.opcode)
            wpf_pkg::OP_TICK: begin
              pose_x_d = in_data_i.x_coord;
              pose_y_d = in_data_i.y_coord;
              hd_d     = in_data_i.heading;
              if (in_data_i.x_coord == '0 && in_data_i.y_coord == '0) begin
                // no pose yet: silent
              end else if (!following_q || paused_q) begin
                out_valid_d = 1'b1;
              end else if (target_q >= count_q) begin
                following_d  = 1'b0;
                plan_d       = 1'b0;
                out_d.has_twist = 1'b0;
                out_d.status = wpf_pkg::ST_DONE;
                out_valid_d  = 1'b1;
              end else begin
                state_d = wpf_pkg::S_DIFF;
              end
            end
            wpf_pkg::OP_NEW: begin
              count_d      = '0;
              target_d     = '0;
              plan_d       = 1'b1;
              following_d  = 1'b0;
              paused_d     = 1'b0;
              out_d.has_twist = 1'b0;
              out_d.status = wpf_pkg::ST_PLAN;
              out_valid_d  = 1'b1;
            end
            wpf_pkg::OP_ADD: begin
              if (mem_we) begin
                count_d = count_q + 1'b1;
              end
            end
            wpf_pkg::OP_CLEAR: begin
              count_d      = '0;
              plan_d       = 1'b0;
              following_d  = 1'b0;
              paused_d     = 1'b0;
              out_d.status = wpf_pkg::ST_CLEARED;
              out_valid_d  = 1'b1;
            end
            default: begin
              if (!plan_q) begin
                out_d.has_twist = 1'b0;
                out_d.status = wpf_pkg::ST_NO_PATH;
                out_valid_d  = 1'b1;
              end else begin
                case (in_data_i.opcode)
                  wpf_pkg::OP_FIRST: begin
                    target_d    = '0;
                    following_d = 1'b1;
                    paused_d    = 1'b0;
                  end
                  wpf_pkg::OP_NEAREST: begin
                    if (count_q == '0) begin
                      target_d    = '0;
                      following_d = 1'b1;
                      paused_d    = 1'b0;
                    end else begin
                      scan_d  = '0;
                      state_d = wpf_pkg::S_NDIFF;
                    end
                  end
                  wpf_pkg::OP_PAUSE: begin
                    paused_d    = 1'b1;
                    out_valid_d = 1'b1;
                  end
                  default: begin
                    paused_d = 1'b0;
                  end
                endcase
              end
            end
          endcase
        end
      end

      wpf_pkg::S_DIFF: begin
        ax_d   = adx[31:0];
        ay_d   = ady[31:0];
        zero_d = (dx == '0) && (dy == '0);
        it_d   = '0;
        if (dx[32]) begin
          cx_d = -36'(dx);
          cy_d = -36'(dy);
          cz_d = dy[32] ? -wpf_pkg::PI_Q16 : wpf_pkg::PI_Q16;
        end else begin
          cx_d = 36'(dx);
          cy_d = 36'(dy);
          cz_d = '0;
        end
        state_d = wpf_pkg::S_CORD;
      end

      wpf_pkg::S_CORD: begin
        if (cy_q > 36'sd0) begin
          cx_d = cx_q + shy;
          cy_d = cy_q - shx;
          cz_d = cz_q + atan_s;
        end else begin
          cx_d = cx_q - shy;
          cy_d = cy_q + shx;
          cz_d = cz_q - atan_s;
        end
        it_d = it_q + 1'b1;
        if (it_q == wpf_pkg::IT_W'(wpf_pkg::CORDIC_STEPS - 1)) begin
          state_d = wpf_pkg::S_ERR;
        end
      end

      wpf_pkg::S_ERR: begin
        if (e_raw > wpf_pkg::PI_Q13) begin
          err_d = e_raw - wpf_pkg::TWO_PI_Q13;
        end else if (e_raw < -wpf_pkg::PI_Q13) begin
          err_d = e_raw + wpf_pkg::TWO_PI_Q13;
        end else begin
          err_d = e_raw;
        end
        state_d = wpf_pkg::S_TMUL;
      end

      wpf_pkg::S_TMUL: begin
        mul_a   = {16'd0, rotfin_q ? drv_gain_q : rot_gain_q};
        mul_b   = {14'd0, err_mag};
        state_d = wpf_pkg::S_TURN;
      end

      wpf_pkg::S_TURN: begin
        out_d = '{has_twist: 1'b1, linear_speed: '0, turn_rate: '0,
                  status: wpf_pkg::ST_NONE};
        turn_d = turn_c;
        if (!rotfin_q) begin
          if (err_mag > {3'd0, ang_tol_q}) begin
            out_d.turn_rate = turn_c;
          end else begin
            rotfin_d = 1'b1;
          end
          out_valid_d = 1'b1;
          state_d     = wpf_pkg::S_IDLE;
        end else if (ax_q > {1'b0, arrive_q} || ay_q > {1'b0, arrive_q}) begin
          out_d.linear_speed = cruise_q;
          out_d.turn_rate    = turn_c;
          out_valid_d        = 1'b1;
          state_d            = wpf_pkg::S_IDLE;
        end else begin
          state_d = wpf_pkg::S_SQX;
        end
      end

      wpf_pkg::S_SQX: begin
        mul_a   = ax_q;
        mul_b   = ax_q;
        state_d = wpf_pkg::S_SQY;
      end

      wpf_pkg::S_SQY: begin
        sq_d    = {1'b0, mul_q};
        mul_a   = ay_q;
        mul_b   = ay_q;
        state_d = wpf_pkg::S_SQR;
      end

      wpf_pkg::S_SQR: begin
        sq_d    = sum_n;
        mul_a   = {1'b0, arrive_q};
        mul_b   = {1'b0, arrive_q};
        state_d = wpf_pkg::S_DCMP;
      end

      wpf_pkg::S_DCMP: begin
        out_d = '{has_twist: 1'b1, linear_speed: '0, turn_rate: '0,
                  status: wpf_pkg::ST_NONE};
        if (sq_q > {1'b0, mul_q}) begin
          out_d.linear_speed = cruise_q;
          out_d.turn_rate    = turn_q;
        end else begin
          rotfin_d = 1'b0;
          target_d = target_q + 1'b1;
          if (target_q + 1'b1 >= count_q) begin
            following_d  = 1'b0;
            plan_d       = 1'b0;
            out_d.status = wpf_pkg::ST_DONE;
          end
        end
        out_valid_d = 1'b1;
        state_d     = wpf_pkg::S_IDLE;
      end

      wpf_pkg::S_NDIFF: begin
        ax_d    = adx[31:0];
        ay_d    = ady[31:0];
        state_d = wpf_pkg::S_NSQX;
      end

      wpf_pkg::S_NSQX: begin
        mul_a   = ax_q;
        mul_b   = ax_q;
        state_d = wpf_pkg::S_NSQY;
      end

      wpf_pkg::S_NSQY: begin
        sq_d    = {1'b0, mul_q};
        mul_a   = ay_q;
        mul_b   = ay_q;
        state_d = wpf_pkg::S_NCMP;
      end

      wpf_pkg::S_NCMP: begin
        rd_addr = scan_q[wpf_pkg::PT_AW-1:0] + 1'b1;
        // first minimum wins: strict compare
        if (scan_q == '0 || sum_n < best_q) begin
          best_d     = sum_n;
          best_idx_d = scan_q;
        end
        if (scan_q + 1'b1 >= count_q) begin
          target_d    = best_idx_d;
          following_d = 1'b1;
          paused_d    = 1'b0;
          state_d     = wpf_pkg::S_IDLE;
        end else begin
          scan_d  = scan_q + 1'b1;
          state_d = wpf_pkg::S_NDIFF;
        end
      end

      default: begin
        state_d = wpf_pkg::S_IDLE;
      end
    endcase
  end

endmodule

### rtl/core/wpf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpf_checker
// Port-level checks for the waypoint path follower, bound to the top level.
// ----------------------------------------------------------------------------
module wpf_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_o,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input wpf_pkg::out_t out_data_o
);

  // a held result word stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result word changed while stalled");

  // one word in flight at a time
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |-> !out_valid_o)
    else $error("word accepted while result pending");

  a_zero_twist: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.has_twist |->
      out_data_o.linear_speed == '0 && out_data_o.turn_rate == '0)
    else $error("motion fields set without twist");

  // driving words never carry a status
  a_drive_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.linear_speed != '0 |->
      out_data_o.has_twist && out_data_o.status == wpf_pkg::ST_NONE)
    else $error("drive word with status");

endmodule

bind waypoint_path_follower_core wpf_checker u_wpf_checker (.*);

### tb/waypoint_path_follower_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// waypoint_path_follower_core_test
// Self-checking bench for the waypoint follower: a twist predictor tracks the
// path state and gains, every accepted command word is predicted and every
// result word is compared in order. Directed corner cases come first, then
// random plan/point/start/tick sequences under several gain settings, with
// bursty input, a stalling receiver and one long output hold-off.
// ----------------------------------------------------------------------------
module waypoint_path_follower_core_test;

  localparam int LIMIT  = 1000000;
  localparam int SETTLE = 1500;    // covers a nearest walk over a full store
  localparam int IN_W   = $bits(wpf_pkg::in_t);

  class twist_predictor;
    wpf_pkg::out_t twist_q[$];
    int          errors;
    int unsigned rot_gain, drv_gain, ang_tol, arrive, cruise, turn_lim;
    longint      px[wpf_pkg::MAX_POINTS];
    longint      py[wpf_pkg::MAX_POINTS];
    int unsigned cnt, tgt;
    bit          following, loaded, paused, rot_done;
    longint      pose_x, pose_y;
    int          atan_tab[16] = '{51472, 30385, 16055, 8150, 4091, 2047, 1024, 512,
                                  256, 128, 64, 32, 16, 8, 4, 2};

    function new();
      rot_gain = 6144; drv_gain = 4096; ang_tol = 82;
      arrive = 3277; cruise = 819; turn_lim = 4096;
      cnt = 0; tgt = 0; following = 0; loaded = 0; paused = 0; rot_done = 0;
      pose_x = 0; pose_y = 0; errors = 0;
    endfunction

    function void set_reg(wpf_pkg::cfg_e idx, logic [31:0] v);
      case (idx)
        wpf_pkg::CFG_ROT_GAIN: rot_gain = v[15:0];
        wpf_pkg::CFG_DRV_GAIN: drv_gain = v[15:0];
        wpf_pkg::CFG_ANG_TOL:  ang_tol  = v[14:0];
        wpf_pkg::CFG_ARRIVE:   arrive   = v[30:0];
        wpf_pkg::CFG_CRUISE:   cruise   = v[14:0];
        wpf_pkg::CFG_TURN_LIM: turn_lim = v[14:0];
        default: ;
      endcase
    endfunction

    function void push(bit tw, longint lin, longint turn, wpf_pkg::status_e st);
      wpf_pkg::out_t o;
      o.has_twist    = tw;
      o.linear_speed = lin[14:0];
      o.turn_rate    = turn[15:0];
      o.status       = st;
      twist_q.push_back(o);
    endfunction

    // CORDIC vectoring, rad Q16 accumulated, rounded to Q13
    function longint goal_angle(longint y, longint x);
      longint z, nx;
      z = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
        z = (y >= 0) ? 205887 : -205887;
        x = -x;
        y = -y;
      end
      for (int i = 0; i < wpf_pkg::CORDIC_STEPS && i < 16; i++) begin
        if (y > 0) begin
          nx = x + (y >>> i);
          y  = y - (x >>> i);
          z += atan_tab[i];
        end else begin
          nx = x - (y >>> i);
          y  = y + (x >>> i);
          z -= atan_tab[i];
        end
        x = nx;
      end
      return (z + 4) >>> 3;
    endfunction

    function longint turn_cmd(int unsigned gain, longint err);
      longint t, lim;
      t   = (longint'(gain) * err + 4096) >>> 13;
      lim = turn_lim;
      if (t > lim) t = lim;
      if (t < -lim) t = -lim;
      return t;
    endfunction

    function void sq_sat(longint unsigned v, output longint unsigned hi,
                         output longint unsigned lo);
      if (v >= 64'h1_0000_0000) begin
        hi = 1; lo = 0;
      end else begin
        hi = 0; lo = v * v;
      end
    endfunction

    function void dist2(longint dx, longint dy, output longint unsigned hi,
                        output longint unsigned lo);
      longint unsigned ah, al, bh, bl;
      sq_sat((dx < 0) ? -dx : dx, ah, al);
      sq_sat((dy < 0) ? -dy : dy, bh, bl);
      lo = al + bl;
      hi = ah + bh + ((lo < al) ? 1 : 0);
    endfunction

    function int unsigned nearest();
      int unsigned best;
      longint unsigned bh, bl, h, l;
      best = 0;
      if (cnt == 0) return 0;
      dist2(px[0] - pose_x, py[0] - pose_y, bh, bl);
      for (int unsigned i = 1; i < cnt; i++) begin
        dist2(px[i] - pose_x, py[i] - pose_y, h, l);
        if (h < bh || (h == bh && l < bl)) begin
          bh = h; bl = l; best = i;
        end
      end
      return best;
    endfunction

    function void tick(longint hd);
      longint dx, dy, err, mag_err;
      longint unsigned ax, ay, ar;
      bit far;
      if (pose_x == 0 && pose_y == 0) return;
      if (!following || paused) begin
        push(1, 0, 0, wpf_pkg::ST_NONE);
        return;
      end
      if (tgt >= cnt) begin
        following = 0; loaded = 0;
        push(0, 0, 0, wpf_pkg::ST_DONE);
        return;
      end
      dx  = px[tgt] - pose_x;
      dy  = py[tgt] - pose_y;
      err = goal_angle(dy, dx) - hd;
      while (err > 25736) err -= 51472;
      while (err < -25736) err += 51472;
      if (!rot_done) begin
        mag_err = (err < 0) ? -err : err;
        if (mag_err > ang_tol) push(1, 0, turn_cmd(rot_gain, err), wpf_pkg::ST_NONE);
        else begin
          rot_done = 1;
          push(1, 0, 0, wpf_pkg::ST_NONE);
        end
        return;
      end
      ar  = arrive;
      ax  = (dx < 0) ? -dx : dx;
      ay  = (dy < 0) ? -dy : dy;
      far = 1;
      if (ax <= ar && ay <= ar) far = (ax * ax + ay * ay) > ar * ar;
      if (far) begin
        push(1, cruise, turn_cmd(drv_gain, err), wpf_pkg::ST_NONE);
        return;
      end
      rot_done = 0;
      tgt++;
      if (tgt >= cnt) begin
        following = 0; loaded = 0;
        push(1, 0, 0, wpf_pkg::ST_DONE);
      end else push(1, 0, 0, wpf_pkg::ST_NONE);
    endfunction

    function void accept_command(wpf_pkg::in_t w);
      case (w.opcode)
        wpf_pkg::OP_TICK: begin
          pose_x = w.x_coord;
          pose_y = w.y_coord;
          tick(w.heading);
        end
        wpf_pkg::OP_NEW: begin
          cnt = 0; tgt = 0; loaded = 1; following = 0; paused = 0;
          push(0, 0, 0, wpf_pkg::ST_PLAN);
        end
        wpf_pkg::OP_ADD: begin
          if (cnt < wpf_pkg::MAX_POINTS) begin
            px[cnt] = w.x_coord;
            py[cnt] = w.y_coord;
            cnt++;
          end
        end
        wpf_pkg::OP_CLEAR: begin
          cnt = 0; loaded = 0; following = 0; paused = 0;
          push(1, 0, 0, wpf_pkg::ST_CLEARED);
        end
        default: begin
          if (!loaded) push(0, 0, 0, wpf_pkg::ST_NO_PATH);
          else case (w.opcode)
            wpf_pkg::OP_FIRST: begin
              tgt = 0; following = 1; paused = 0;
            end
            wpf_pkg::OP_NEAREST: begin
              tgt = nearest(); following = 1; paused = 0;
            end
            wpf_pkg::OP_PAUSE: begin
              paused = 1;
              push(1, 0, 0, wpf_pkg::ST_NONE);
            end
            default: paused = 0;
          endcase
        end
      endcase
    endfunction

    function void compare_twist(wpf_pkg::out_t got);
      wpf_pkg::out_t want;
      if (twist_q.size() == 0) begin
        $error("unexpected result word %h", got);
        errors++;
        return;
      end
      want = twist_q.pop_front();
      if (got.has_twist !== want.has_twist) begin
        $error("has_twist: expected %0d, got %0d", want.has_twist, got.has_twist);
        errors++;
      end
      if (got.linear_speed !== want.linear_speed) begin
        $error("linear_speed: expected %0d, got %0d", want.linear_speed,
               got.linear_speed);
        errors++;
      end
      if (got.turn_rate !== want.turn_rate) begin
        $error("turn_rate: expected %0d, got %0d", want.turn_rate, got.turn_rate);
        errors++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        errors++;
      end
    endfunction
  endclass

  logic          clk = 0;
  logic          rst_n = 0;
  logic          in_valid = 0;
  logic          in_ready;
  wpf_pkg::in_t  in_data = '0;
  logic          out_valid;
  logic          out_ready = 0;
  wpf_pkg::out_t out_data;
  logic          cfg_valid = 0;
  logic          cfg_ready;
  logic [2:0]    cfg_index = '0;
  logic [31:0]   cfg_data = '0;

  twist_predictor sb = new();
  int  gap_max, burst_left, rx_mode, hold_n, rx_phase, cycles;
  bit  hold_req;

  waypoint_path_follower_core uut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_data_o(out_data),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  task automatic send(wpf_pkg::in_t w);
    in_valid <= 1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    sb.accept_command(w);
    if (gap_max > 0 && burst_left == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, gap_max)) @(posedge clk);
      burst_left = $urandom_range(1, 12);
    end else if (burst_left > 0) burst_left--;
  endtask

  task automatic cmd(wpf_pkg::op_e op, logic [31:0] x = 0, logic [31:0] y = 0,
                     logic [15:0] hd = 0);
    wpf_pkg::in_t w;
    w.opcode = op; w.x_coord = x; w.y_coord = y; w.heading = hd;
    send(w);
  endtask

  task automatic wait_empty();
    in_valid <= 0;
    while (sb.twist_q.size() != 0) @(posedge clk);
  endtask

  task automatic drain();
    wait_empty();
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic cfg_write(wpf_pkg::cfg_e idx, logic [31:0] v);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, v);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] rand_point();
    if ($urandom_range(0, 9) == 0) return $urandom;
    return $urandom_range(0, 1 << 21) - (1 << 20);
  endfunction

  // pose offset from the current target, heading aimed at it half the time
  task automatic aimed_tick();
    longint tx, ty, off_x, off_y, g;
    int unsigned lim;
    logic [15:0] hd;
    tx = $signed(rand_point()); ty = $signed(rand_point());
    if (sb.following && sb.tgt < sb.cnt) begin
      tx = sb.px[sb.tgt]; ty = sb.py[sb.tgt];
    end
    case ($urandom_range(0, 3))
      0: lim = 0;
      1: lim = 2000;
      2: lim = 200000;
      default: lim = 1 << 24;
    endcase
    off_x = longint'($urandom_range(0, lim)) - longint'(lim / 2);
    off_y = longint'($urandom_range(0, lim)) - longint'(lim / 2);
    g = sb.goal_angle(off_y, off_x) + longint'($urandom_range(0, 120)) - 60;
    hd = $urandom_range(0, 1) ? g[15:0] : 16'($urandom);
    cmd(wpf_pkg::OP_TICK, 32'(tx - off_x), 32'(ty - off_y), hd);
  endtask

  task automatic run_random(int n, bit overfill);
    int done, k, nt, r;
    wpf_pkg::in_t w;
    done = 0;
    if (overfill) begin
      cmd(wpf_pkg::OP_NEW);
      for (int i = 0; i < wpf_pkg::MAX_POINTS + 3; i++)
        cmd(wpf_pkg::OP_ADD, rand_point(), rand_point());
      aimed_tick();
      cmd(wpf_pkg::OP_NEAREST);
      for (int i = 0; i < 10; i++) aimed_tick();
    end
    while (done < n) begin
      if ($urandom_range(0, 99) < 12) begin
        w = wpf_pkg::in_t'(IN_W'({$urandom, $urandom, $urandom}));
        send(w);
        done++;
      end else begin
        cmd(wpf_pkg::OP_NEW);
        k = ($urandom_range(0, 19) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 5);
        for (int i = 0; i < k; i++) cmd(wpf_pkg::OP_ADD, rand_point(), rand_point());
        if ($urandom_range(0, 1)) aimed_tick();
        if ($urandom_range(0, 1)) cmd(wpf_pkg::OP_FIRST);
        else cmd(wpf_pkg::OP_NEAREST);
        nt = $urandom_range(4, 30);
        for (int i = 0; i < nt; i++) begin
          r = $urandom_range(0, 99);
          if (r < 6) cmd(wpf_pkg::OP_PAUSE);
          else if (r < 12) cmd(wpf_pkg::OP_RESUME);
          else if (r < 15) cmd(wpf_pkg::OP_CLEAR);
          else aimed_tick();
        end
        done += k + nt + 3;
      end
    end
  endtask

  // receiver: own stall pattern plus a long hold-off on request
  initial begin
    hold_n = 0; rx_phase = 0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) sb.compare_twist(out_data);
      rx_phase++;
      if (hold_req) begin
        hold_req = 0;
        hold_n = 400;
      end
      if (hold_n > 0) begin
        hold_n--;
        out_ready <= 0;
      end else case (rx_mode)
        0: out_ready <= 1;
        1: out_ready <= ($urandom_range(0, 3) != 0);
        default: out_ready <= (rx_phase % 7 >= 3);
      endcase
    end
  end

  initial begin
    cycles = 0;
    while (cycles < LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Some tests failed");
    $finish;
  end

  initial begin
    gap_max = 0; burst_left = 0; rx_mode = 1; hold_req = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: zero pose, no plan, empty start, extremes, pause/resume, clear
    cmd(wpf_pkg::OP_TICK, 0, 0, 16'h1234);
    cmd(wpf_pkg::OP_FIRST);
    cmd(wpf_pkg::OP_NEAREST);
    cmd(wpf_pkg::OP_PAUSE);
    cmd(wpf_pkg::OP_RESUME);
    cmd(wpf_pkg::OP_TICK, 32'h0001_0000, 32'h0001_0000, 0);
    cmd(wpf_pkg::OP_NEW);
    cmd(wpf_pkg::OP_NEAREST);
    cmd(wpf_pkg::OP_TICK, 32'h0001_0000, 32'h0001_0000, 0);
    cmd(wpf_pkg::OP_NEW);
    cmd(wpf_pkg::OP_ADD, 32'h7FFF_FFFF, 32'h8000_0000);
    cmd(wpf_pkg::OP_ADD, 32'h8000_0000, 32'h7FFF_FFFF);
    cmd(wpf_pkg::OP_ADD, 32'h0001_0000, 0);
    cmd(wpf_pkg::OP_TICK, 32'h0000_8000, 32'hFFFF_0000, 16'h8000);
    cmd(wpf_pkg::OP_NEAREST);
    cmd(wpf_pkg::OP_TICK, 32'h0000_8000, 32'hFFFF_0000, 16'h8000);
    cmd(wpf_pkg::OP_TICK, 32'hFFFF_FFFF, 32'h0000_0001, 16'h7FFF);
    cmd(wpf_pkg::OP_PAUSE);
    cmd(wpf_pkg::OP_TICK, 32'h0000_8000, 32'hFFFF_0000, 0);
    cmd(wpf_pkg::OP_RESUME);
    cmd(wpf_pkg::OP_TICK, 32'h0001_0000, 0, 0);
    cmd(wpf_pkg::OP_TICK, 32'h0001_0000, 0, 0);
    cmd(wpf_pkg::OP_CLEAR);
    cmd(wpf_pkg::OP_TICK, 32'h0001_0000, 0, 0);
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        1: for (int i = wpf_pkg::CFG_ROT_GAIN; i <= wpf_pkg::CFG_TURN_LIM; i++)
             cfg_write(wpf_pkg::cfg_e'(i), $urandom);
        2: for (int i = wpf_pkg::CFG_ROT_GAIN; i <= wpf_pkg::CFG_TURN_LIM; i++)
             cfg_write(wpf_pkg::cfg_e'(i), 0);
        3: begin
          cfg_write(wpf_pkg::CFG_ROT_GAIN, 32'hFFFF);
          cfg_write(wpf_pkg::CFG_DRV_GAIN, 32'hFFFF);
          cfg_write(wpf_pkg::CFG_ANG_TOL, 32'h7FFF);
          cfg_write(wpf_pkg::CFG_ARRIVE, 32'h7FFF_FFFF);
          cfg_write(wpf_pkg::CFG_CRUISE, 32'h7FFF);
          cfg_write(wpf_pkg::CFG_TURN_LIM, 32'h7FFF);
        end
        4: begin
          cfg_write(wpf_pkg::CFG_ROT_GAIN, $urandom_range(0, 20000));
          cfg_write(wpf_pkg::CFG_DRV_GAIN, $urandom_range(0, 20000));
          cfg_write(wpf_pkg::CFG_ANG_TOL, $urandom_range(20, 400));
          cfg_write(wpf_pkg::CFG_ARRIVE, $urandom_range(1000, 300000));
          cfg_write(wpf_pkg::CFG_CRUISE, $urandom_range(0, 32767));
          cfg_write(wpf_pkg::CFG_TURN_LIM, $urandom_range(1, 32767));
        end
        default: ;
      endcase
      gap_max = (ph == 3) ? 0 : 20;
      rx_mode = (ph == 3) ? 0 : ph % 2 + 1;
      run_random(15, 0);
      if (ph == 1) hold_req = 1;     // receiver holds while input keeps coming
      if (ph == 2) wait_empty();     // sender waits for all results
      run_random(15, ph == 4);
      drain();
    end

    if (sb.errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
